@@ design/multi_button_press_classifier_top_assert.svh @@
// Assertion macros for the button press classifier.
// Every assertion is clocked on the rising edge and disabled during reset.
`ifndef MULTI_BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define MULTI_BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// Implication that must hold on every edge outside reset.
`define MBPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on every edge outside reset.
`define MBPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ design/mbpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbpc_pkg
// Shared constants and types of the button press classifier.
// ----------------------------------------------------------------------------
package mbpc_pkg;

    localparam int NUM_BUTTONS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam int LEVEL_BITS  = 16;
    localparam int NOW_BITS    = 32;
    localparam int MASK_BITS   = 16;
    localparam int THRESH_BITS = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = THRESH_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_PRESS = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS  = CFG_INDEX_BITS'(1);

    localparam logic [THRESH_BITS-1:0] SHORT_PRESS_RESET = THRESH_BITS'(60);
    localparam logic [THRESH_BITS-1:0] LONG_PRESS_RESET  = THRESH_BITS'(500);

    // Events one lane reports for the current scan.
    typedef struct packed {
        logic short_release;
        logic hold_begin;
        logic hold_release;
    } lane_evt_t;

endpackage

@@ design/mbpc_lane.sv @@
// ----------------------------------------------------------------------------
// mbpc_lane
// Press tracker for one button: start time, timing flag and press phase.
// ----------------------------------------------------------------------------
module mbpc_lane #(
    parameter int TIME_BITS = mbpc_pkg::TIME_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               pressed,
    input  logic [TIME_BITS-1:0]               now,
    input  logic [mbpc_pkg::THRESH_BITS-1:0]   short_ms,
    input  logic [mbpc_pkg::THRESH_BITS-1:0]   long_ms,
    output mbpc_pkg::lane_evt_t                evt
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SHORT = 2'd1,
        PH_HELD  = 2'd2,
        PH_SPARE = 2'd3
    } phase_t;

    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 active_reg, active_next;
    phase_t               phase_reg, phase_next;

    logic [TIME_BITS-1:0] elapsed;
    logic                 short_ok, long_ok;
    phase_t               mid_phase;

    // wraps modulo 2^TIME_BITS
    assign elapsed  = now - start_reg;
    assign short_ok = elapsed >= TIME_BITS'(short_ms);
    assign long_ok  = elapsed >= TIME_BITS'(long_ms);

    always_comb
    begin
        start_next  = start_reg;
        active_next = active_reg;
        phase_next  = phase_reg;
        mid_phase   = phase_reg;
        evt         = '0;
        if (pressed)
        begin
            if (!active_reg)
            begin
                start_next  = now;
                active_next = 1'b1;
            end
            else
            begin
                // both steps may land in the same scan
                if (short_ok && phase_reg == PH_IDLE)
                begin
                    mid_phase = PH_SHORT;
                end
                if (long_ok && mid_phase == PH_SHORT)
                begin
                    phase_next     = PH_HELD;
                    evt.hold_begin = 1'b1;
                end
                else
                begin
                    phase_next = mid_phase;
                end
            end
        end
        else
        begin
            evt.hold_release  = (phase_reg == PH_HELD);
            evt.short_release = (phase_reg == PH_SHORT);
            start_next        = '0;
            active_next       = 1'b0;
            phase_next        = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            active_reg <= 1'b0;
            phase_reg  <= PH_IDLE;
        end
        else if (accept)
        begin
            start_reg  <= start_next;
            active_reg <= active_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

@@ design/mbpc_merge.sv @@
// ----------------------------------------------------------------------------
// mbpc_merge
// Gathers lane events into the three event masks and holds the output word.
// ----------------------------------------------------------------------------
module mbpc_merge #(
    parameter int NUM_BUTTONS = mbpc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  mbpc_pkg::lane_evt_t [NUM_BUTTONS-1:0]  evt,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [mbpc_pkg::MASK_BITS-1:0]         short_release_mask,
    output logic [mbpc_pkg::MASK_BITS-1:0]         hold_begin_mask,
    output logic [mbpc_pkg::MASK_BITS-1:0]         hold_release_mask
);

    logic [mbpc_pkg::MASK_BITS-1:0] short_next, begin_next, rel_next;
    logic [mbpc_pkg::MASK_BITS-1:0] short_reg, begin_reg, rel_reg;
    logic                           valid_reg, valid_next;

    // lanes past the mask width are tracked but not reported
    for (genvar i = 0; i < mbpc_pkg::MASK_BITS; i++)
    begin : g_bit
        if (i < NUM_BUTTONS)
        begin : g_lane
            assign short_next[i] = evt[i].short_release;
            assign begin_next[i] = evt[i].hold_begin;
            assign rel_next[i]   = evt[i].hold_release;
        end
        else
        begin : g_none
            assign short_next[i] = 1'b0;
            assign begin_next[i] = 1'b0;
            assign rel_next[i]   = 1'b0;
        end
    end

    assign valid_next = load | (valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            short_reg <= short_next;
            begin_reg <= begin_next;
            rel_reg   <= rel_next;
        end
    end

    assign out_valid          = valid_reg;
    assign short_release_mask = short_reg;
    assign hold_begin_mask    = begin_reg;
    assign hold_release_mask  = rel_reg;

endmodule

@@ design/multi_button_press_classifier_top.sv @@
// Every lane updates its state in the accept cycle; the result word is valid in the
// cycle after. Throughput: one scan per cycle while in_ready is high.
// The single output register takes a new word whenever it is empty or being read.
// Reset (rst_n low, async): all lanes idle with timing cleared, thresholds 60 / 500 ms,
// no result pending.
// ----------------------------------------------------------------------------
// multi_button_press_classifier_top
// Short and long press detector for a bank of active-low buttons.
// ----------------------------------------------------------------------------
module multi_button_press_classifier_top #(
    parameter int NUM_BUTTONS = mbpc_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = mbpc_pkg::TIME_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mbpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mbpc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mbpc_pkg::LEVEL_BITS-1:0]      button_levels,
    input  logic [mbpc_pkg::NOW_BITS-1:0]        now_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mbpc_pkg::MASK_BITS-1:0]       short_release_mask,
    output logic [mbpc_pkg::MASK_BITS-1:0]       hold_begin_mask,
    output logic [mbpc_pkg::MASK_BITS-1:0]       hold_release_mask
);

    logic [mbpc_pkg::THRESH_BITS-1:0] short_ms_reg, long_ms_reg;
    logic                             accept;
    logic [TIME_BITS-1:0]             now;
    mbpc_pkg::lane_evt_t [NUM_BUTTONS-1:0] evt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_ms_reg <= mbpc_pkg::SHORT_PRESS_RESET;
            long_ms_reg  <= mbpc_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mbpc_pkg::REG_SHORT_PRESS: short_ms_reg <= cfg_data;
                mbpc_pkg::REG_LONG_PRESS:  long_ms_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = ~out_valid | out_ready;
    assign accept   = in_valid & in_ready;
    assign now      = TIME_BITS'(now_ms);

    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        logic pressed;
        // buttons past the input width read as pressed
        if (i < mbpc_pkg::LEVEL_BITS)
        begin : g_pin
            assign pressed = ~button_levels[i];
        end
        else
        begin : g_nopin
            assign pressed = 1'b1;
        end

        mbpc_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .accept   (accept),
            .pressed  (pressed),
            .now      (now),
            .short_ms (short_ms_reg),
            .long_ms  (long_ms_reg),
            .evt      (evt[i])
        );
    end

    mbpc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk                (clk),
        .rst_n              (rst_n),
        .load               (accept),
        .evt                (evt),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .short_release_mask (short_release_mask),
        .hold_begin_mask    (hold_begin_mask),
        .hold_release_mask  (hold_release_mask)
    );

endmodule

@@ design/mbpc_checker.sv @@
// ----------------------------------------------------------------------------
// mbpc_checker
// Port-level checks of the button press classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_button_press_classifier_top_assert.svh"

module mbpc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [mbpc_pkg::MASK_BITS-1:0] short_release_mask,
    input logic [mbpc_pkg::MASK_BITS-1:0] hold_begin_mask,
    input logic [mbpc_pkg::MASK_BITS-1:0] hold_release_mask
);

    // input side stalls only while a result word waits
    `MBPC_ASSERT_ALWAYS(a_ready_rule, clk, rst_n, in_ready == (!out_valid || out_ready), "in_ready does not follow output register")

    `MBPC_ASSERT(a_accept_to_out, clk, rst_n, (in_valid && in_ready) |=> out_valid, "accepted scan gave no result word")

    `MBPC_ASSERT(a_no_phantom, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready), "result word without accepted scan")

    // a button is released or pressed in one scan, never both, and has one phase
    `MBPC_ASSERT_ALWAYS(a_mask_excl, clk, rst_n, !out_valid || (((short_release_mask & hold_release_mask) == '0) && ((hold_begin_mask & (short_release_mask | hold_release_mask)) == '0)), "event masks overlap")

    `MBPC_ASSERT(a_hold_stall, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(hold_begin_mask) && $stable(short_release_mask) && $stable(hold_release_mask)), "stalled result word changed")

endmodule

bind multi_button_press_classifier_top mbpc_checker u_mbpc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .short_release_mask (short_release_mask),
    .hold_begin_mask    (hold_begin_mask),
    .hold_release_mask  (hold_release_mask)
);
